// ----- design/qtt_pkg.sv -----
// Shared types, character codes and scan modes for the query text tokenizer.
// No dependencies; every other file of the block but qtt_if.sv imports this package.
package qtt_pkg;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_IDENT   = 3'd1;
   localparam logic [2:0] MODE_NUMBER  = 3'd2;
   localparam logic [2:0] MODE_STRING  = 3'd3;
   localparam logic [2:0] MODE_SYMPEND = 3'd4;

   localparam logic [2:0] KIND_IDENT  = 3'd0;
   localparam logic [2:0] KIND_NUMBER = 3'd1;
   localparam logic [2:0] KIND_STRING = 3'd2;
   localparam logic [2:0] KIND_SYMBOL = 3'd3;
   localparam logic [2:0] KIND_END    = 3'd4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   localparam int MAX_RESULTS = 3;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] char_out;
      logic       has_char;
      logic       token_first;
      logic       token_last;
   } qtt_result_type;

   // All results of one input byte; count is 0..MAX_RESULTS, and only groups with a nonzero count are pushed
   typedef struct packed {
      logic [1:0]                             count;
      qtt_result_type [MAX_RESULTS-1:0]       res;
   } qtt_group_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qtt_queue_status_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [2:0] mode_kind(input logic [2:0] m);
      logic [2:0] k;
      unique case (m)
         MODE_IDENT:  k = KIND_IDENT;
         MODE_NUMBER: k = KIND_NUMBER;
         MODE_STRING: k = KIND_STRING;
         default:     k = KIND_SYMBOL;
      endcase
      return k;
   endfunction

   function automatic qtt_result_type make_result(input logic [2:0] kind, input logic [7:0] ch,
                                                  input logic has, input logic first,
                                                  input logic last);
      qtt_result_type r;
      r.token_kind  = kind;
      r.char_out    = ch;
      r.has_char    = has;
      r.token_first = first;
      r.token_last  = last;
      return r;
   endfunction

endpackage

// ----- design/qtt_if.sv -----
// Valid/ready channel interfaces for the tokenizer's byte input and token output.
// No dependencies.
interface qtt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       final_char;

   modport source (output valid, output char_in, output final_char, input ready);
   modport sink   (input valid, input char_in, input final_char, output ready);
endinterface

interface qtt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] token_kind;
   logic [7:0] char_out;
   logic       has_char;
   logic       token_first;
   logic       token_last;
   logic       item_last;

   modport source (output valid, output token_kind, output char_out, output has_char,
                   output token_first, output token_last, output item_last, input ready);
   modport sink   (input valid, input token_kind, input char_out, input has_char,
                   input token_first, input token_last, input item_last, output ready);
endinterface

// ----- design/qtt_front.sv -----
// Scanner front end: accepts one byte per beat, advances the scan state and
// builds the group of results the byte causes. Uses qtt_pkg and qtt_req_if.
module qtt_front (
   input  logic                         clock,
   input  logic                         reset,
   qtt_req_if.sink                      req,
   input  qtt_pkg::qtt_queue_status_type q_status,
   output logic                         push,
   output qtt_pkg::qtt_group_type       group
);
   import qtt_pkg::*;

   logic [2:0] mode_ff, mode_in;
   logic [7:0] hc_ff, hc_in;
   logic       hv_ff, hv_in;
   logic       hf_ff, hf_in;

   logic [7:0]    c;
   logic          fin;
   logic          cont;
   logic          do_close;
   logic          do_idle;
   logic [1:0]    n;
   qtt_group_type g;
   logic          accept;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      c        = req.char_in;
      fin      = req.final_char;
      mode_in  = mode_ff;
      hc_in    = hc_ff;
      hv_in    = hv_ff;
      hf_in    = hf_ff;
      n        = 2'd0;
      g        = '0;
      cont     = 1'b0;
      do_close = 1'b0;
      do_idle  = 1'b0;

      if (c != CH_NUL) begin
         unique case (mode_in)
            MODE_IDENT, MODE_NUMBER: begin
               cont = (mode_in == MODE_IDENT) ? (is_alpha(c) || is_digit(c) || c == CH_UNDER)
                                              : (is_digit(c) || c == CH_DOT);
               if (cont && hv_in) begin
                  g.res[n] = make_result(mode_kind(mode_in), hc_in, 1'b1, hf_in, 1'b0);
                  n        = n + 2'd1;
                  hc_in    = c;
                  hf_in    = 1'b0;
               end else begin
                  do_close = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  do_close = 1'b1;
               end else if (hv_in) begin
                  g.res[n] = make_result(KIND_STRING, hc_in, 1'b1, hf_in, 1'b0);
                  n        = n + 2'd1;
                  hc_in    = c;
                  hf_in    = 1'b0;
               end else begin
                  hc_in = c;
                  hv_in = 1'b1;
                  hf_in = 1'b1;
               end
            end
            MODE_SYMPEND: begin
               if (c == CH_EQ && hv_in) begin
                  g.res[n] = make_result(KIND_SYMBOL, hc_in, 1'b1, 1'b1, 1'b0);
                  n        = n + 2'd1;
                  g.res[n] = make_result(KIND_SYMBOL, CH_EQ, 1'b1, 1'b0, 1'b1);
                  n        = n + 2'd1;
                  mode_in  = MODE_IDLE;
                  hc_in    = CH_NUL;
                  hv_in    = 1'b0;
                  hf_in    = 1'b0;
               end else begin
                  do_close = 1'b1;
                  do_idle  = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         endcase

         // Flush the held byte as the token's last character; an empty string still gives one result
         if (do_close) begin
            if (hv_in) begin
               g.res[n] = make_result(mode_kind(mode_in), hc_in, 1'b1, hf_in, 1'b1);
               n        = n + 2'd1;
            end else if (mode_in == MODE_STRING) begin
               g.res[n] = make_result(KIND_STRING, CH_NUL, 1'b0, 1'b1, 1'b1);
               n        = n + 2'd1;
            end
            mode_in = MODE_IDLE;
            hc_in   = CH_NUL;
            hv_in   = 1'b0;
            hf_in   = 1'b0;
         end

         // Rescan the byte as the start of a new token
         if (do_idle && !is_space(c)) begin
            if (is_alpha(c)) begin
               mode_in = MODE_IDENT;
               hc_in   = c;
               hv_in   = 1'b1;
               hf_in   = 1'b1;
            end else if (is_digit(c)) begin
               mode_in = MODE_NUMBER;
               hc_in   = c;
               hv_in   = 1'b1;
               hf_in   = 1'b1;
            end else if (c == CH_QUOTE) begin
               mode_in = MODE_STRING;
               hv_in   = 1'b0;
               hf_in   = 1'b0;
            end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
               mode_in = MODE_SYMPEND;
               hc_in   = c;
               hv_in   = 1'b1;
               hf_in   = 1'b1;
            end else begin
               g.res[n] = make_result(KIND_SYMBOL, c, 1'b1, 1'b1, 1'b1);
               n        = n + 2'd1;
            end
         end
      end

      if (c == CH_NUL || fin) begin
         if (mode_in != MODE_IDLE) begin
            if (hv_in) begin
               g.res[n] = make_result(mode_kind(mode_in), hc_in, 1'b1, hf_in, 1'b1);
               n        = n + 2'd1;
            end else if (mode_in == MODE_STRING) begin
               g.res[n] = make_result(KIND_STRING, CH_NUL, 1'b0, 1'b1, 1'b1);
               n        = n + 2'd1;
            end
         end
         g.res[n] = make_result(KIND_END, CH_NUL, 1'b0, 1'b1, 1'b1);
         n        = n + 2'd1;
         mode_in  = MODE_IDLE;
         hc_in    = CH_NUL;
         hv_in    = 1'b0;
         hf_in    = 1'b0;
      end

      g.count = n;
   end

   assign group = g;
   assign push  = accept && (n != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         hv_ff   <= 1'b0;
         hf_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         hv_ff   <= hv_in;
         hf_ff   <= hf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hc_ff <= hc_in;
      end
   end

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      accept && (req.char_in == CH_NUL || req.final_char) |=> mode_ff == MODE_IDLE && !hv_ff)
      else $error("scan state not cleared after end of input");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> !hv_ff)
      else $error("byte held while idle");

   a_sympend_held: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_SYMPEND |-> hv_ff && hf_ff)
      else $error("pending symbol without its held byte");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("group pushed into full queue");

endmodule

// ----- design/qtt_fifo.sv -----
// Short queue of result groups between the scanner front end and the emitter.
// Uses qtt_pkg.
module qtt_fifo #(
   parameter int Depth = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  qtt_pkg::qtt_group_type        wr_group,
   input  logic                          pop,
   output qtt_pkg::qtt_group_type        head,
   output qtt_pkg::qtt_queue_status_type status
);
   import qtt_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   qtt_group_type   mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CntW'(Depth));
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_group;
      end
   end

endmodule

// ----- design/qtt_back.sv -----
// Emitter: walks the head group one result per beat into the output register
// and marks the last result of each byte. Uses qtt_pkg and qtt_rsp_if.
module qtt_back (
   input  logic                          clock,
   input  logic                          reset,
   input  qtt_pkg::qtt_group_type        head,
   input  qtt_pkg::qtt_queue_status_type q_status,
   output logic                          pop,
   qtt_rsp_if.source                     rsp
);
   import qtt_pkg::*;

   logic           valid_ff;
   qtt_result_type res_ff;
   logic           item_last_ff;
   logic [1:0]     idx_ff, idx_in;
   logic           load;
   logic           take;
   logic           at_last;

   assign load    = !valid_ff || rsp.ready;
   assign take    = load && !q_status.empty;
   assign at_last = (idx_ff == head.count - 2'd1);
   assign pop     = take && at_last;
   assign idx_in  = at_last ? 2'd0 : idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= !q_status.empty;
         if (take) begin
            idx_ff <= idx_in;
         end
      end
   end

   // Hold the payload while the beat is stalled
   always_ff @(posedge clock) begin
      if (take) begin
         res_ff       <= head.res[idx_ff];
         item_last_ff <= at_last;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.token_kind  = res_ff.token_kind;
   assign rsp.char_out    = res_ff.char_out;
   assign rsp.has_char    = res_ff.has_char;
   assign rsp.token_first = res_ff.token_first;
   assign rsp.token_last  = res_ff.token_last;
   assign rsp.item_last   = item_last_ff;

endmodule

// ----- design/query_text_tokenizer.sv -----
// Query text tokenizer: one byte in per beat, one result out per beat.
// With the queue empty, a byte's first result passes through the group queue and the
// output register before rsp offers it. Throughput: one byte per cycle while results
// average at most one per byte; the emitter drains one result per cycle while rsp is
// ready, and the queue holds QueueDepth groups of up to 3 results before input stalls.
// Reset (synchronous, active high) empties the queue and returns the scanner to idle.
module query_text_tokenizer #(
   parameter int QueueDepth = 4
) (
   input  logic      clock,
   input  logic      reset,
   qtt_req_if.sink   req_chan,
   qtt_rsp_if.source rsp_chan
);
   import qtt_pkg::*;

   logic                 push;
   logic                 pop;
   qtt_group_type        wr_group;
   qtt_group_type        head;
   qtt_queue_status_type q_status;

   qtt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .q_status (q_status),
      .push     (push),
      .group    (wr_group)
   );

   qtt_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_group (wr_group),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   qtt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for query_text_tokenizer: directed table, then random query text.
// Depends on qtt_pkg and the qtt_req_if / qtt_rsp_if channel interfaces.
module tb;
   import qtt_pkg::*;

   localparam int HOLD_OFF_CYCLES = 60;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int NUM_DIRECTED    = 25;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      logic       has_ch;
      logic       tfirst;
      logic       tlast;
      logic       ilast;
   } tok_type;

   // One input beat; typed rows carry their results, the rest go through the scanner copy
   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
      logic       typed;
      logic [1:0] cnt;
      tok_type    t0;
      tok_type    t1;
      tok_type    t2;
   } row_type;

   localparam tok_type NO_TOK = '0;

   logic clock;
   logic reset;

   qtt_req_if req_bus ();
   qtt_rsp_if rsp_bus ();

   query_text_tokenizer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // scanner copy
   logic [2:0] lex_mode;
   logic [7:0] held_byte;
   logic       held_ok;
   logic       held_starts;

   tok_type step_tokens[$];
   tok_type expected_tokens[$];
   row_type text_q[$];
   row_type directed_rows [NUM_DIRECTED];

   int fail_count    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   bit hold_request  = 0;

   function automatic tok_type tk(input logic [2:0] kind, input logic [7:0] ch,
                                  input logic has_ch, input logic tfirst, input logic tlast,
                                  input logic ilast);
      tok_type t;
      t.kind   = kind;
      t.ch     = ch;
      t.has_ch = has_ch;
      t.tfirst = tfirst;
      t.tlast  = tlast;
      t.ilast  = ilast;
      return t;
   endfunction

   function automatic row_type pr(input logic [7:0] ch, input logic fin);
      row_type r;
      r     = '0;
      r.ch  = ch;
      r.fin = fin;
      return r;
   endfunction

   function automatic row_type tr(input logic [7:0] ch, input logic fin, input logic [1:0] cnt,
                                  input tok_type t0, input tok_type t1, input tok_type t2);
      row_type r;
      r       = pr(ch, fin);
      r.typed = 1'b1;
      r.cnt   = cnt;
      r.t0    = t0;
      r.t1    = t1;
      r.t2    = t2;
      return r;
   endfunction

   function void add_text(input row_type r);
      text_q.insert(text_q.size(), r);
   endfunction

   function void add_expected(input tok_type t);
      expected_tokens.insert(expected_tokens.size(), t);
   endfunction

   function automatic logic letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic blank(input logic [7:0] c);
      return c == " " || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [2:0] kind_of_mode(input logic [2:0] m);
      case (m)
         MODE_IDENT:  return KIND_IDENT;
         MODE_NUMBER: return KIND_NUMBER;
         MODE_STRING: return KIND_STRING;
         default:     return KIND_SYMBOL;
      endcase
   endfunction

   function void emit(input logic [2:0] kind, input logic [7:0] ch, input logic has_ch,
                      input logic tfirst, input logic tlast);
      step_tokens.insert(step_tokens.size(), tk(kind, ch, has_ch, tfirst, tlast, 1'b0));
   endfunction

   function void clear_scan();
      lex_mode    = MODE_IDLE;
      held_byte   = '0;
      held_ok     = 1'b0;
      held_starts = 1'b0;
   endfunction

   function void hold_char(input logic [7:0] c, input logic starts);
      held_byte   = c;
      held_ok     = 1'b1;
      held_starts = starts;
   endfunction

   // Emit the held byte as the token's last; an empty string still gives one result
   function void flush_token();
      if (held_ok)
         emit(kind_of_mode(lex_mode), held_byte, 1'b1, held_starts, 1'b1);
      else if (lex_mode == MODE_STRING)
         emit(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
      clear_scan();
   endfunction

   function void start_token(input logic [7:0] c);
      if (blank(c))
         return;
      if (letter(c)) begin
         lex_mode = MODE_IDENT;
         hold_char(c, 1'b1);
      end else if (digit(c)) begin
         lex_mode = MODE_NUMBER;
         hold_char(c, 1'b1);
      end else if (c == CH_QUOTE) begin
         lex_mode    = MODE_STRING;
         held_ok     = 1'b0;
         held_starts = 1'b0;
      end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
         lex_mode = MODE_SYMPEND;
         hold_char(c, 1'b1);
      end else begin
         emit(KIND_SYMBOL, c, 1'b1, 1'b1, 1'b1);
      end
   endfunction

   function void lex_byte(input logic [7:0] c);
      logic cont;
      case (lex_mode)
         MODE_IDENT, MODE_NUMBER: begin
            cont = (lex_mode == MODE_IDENT) ? (letter(c) || digit(c) || c == CH_UNDER)
                                            : (digit(c) || c == CH_DOT);
            if (cont && held_ok) begin
               emit(kind_of_mode(lex_mode), held_byte, 1'b1, held_starts, 1'b0);
               hold_char(c, 1'b0);
            end else begin
               // the terminating byte starts the next token
               flush_token();
               start_token(c);
            end
         end
         MODE_STRING: begin
            if (c == CH_QUOTE) begin
               flush_token();
            end else if (held_ok) begin
               emit(KIND_STRING, held_byte, 1'b1, held_starts, 1'b0);
               hold_char(c, 1'b0);
            end else begin
               hold_char(c, 1'b1);
            end
         end
         MODE_SYMPEND: begin
            if (c == CH_EQ && held_ok) begin
               emit(KIND_SYMBOL, held_byte, 1'b1, 1'b1, 1'b0);
               emit(KIND_SYMBOL, CH_EQ, 1'b1, 1'b0, 1'b1);
               clear_scan();
            end else begin
               flush_token();
               start_token(c);
            end
         end
         default: begin
            lex_mode = MODE_IDLE;
            start_token(c);
         end
      endcase
   endfunction

   // Results caused by one accepted byte, left in step_tokens
   function void scan_text_byte(input logic [7:0] c, input logic fin);
      step_tokens.delete();
      if (c != CH_NUL)
         lex_byte(c);
      if (c == CH_NUL || fin) begin
         if (lex_mode != MODE_IDLE)
            flush_token();
         emit(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
         clear_scan();
      end
      if (step_tokens.size() > 0)
         step_tokens[step_tokens.size() - 1].ilast = 1'b1;
   endfunction

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(0, 1) == 0)
         return 8'(8'h61 + $urandom_range(0, 25));
      return 8'(8'h41 + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'(8'h30 + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_blank();
      if ($urandom_range(0, 5) == 5)
         return 8'h20;
      return 8'(8'h09 + $urandom_range(0, 4));
   endfunction

   // Append one text of token-shaped fragments, with a little noise
   function void compose_text();
      int         n_tok;
      int         len;
      logic [7:0] c;
      n_tok = $urandom_range(1, 6);
      for (int t = 0; t < n_tok; t++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               add_text(pr(rand_letter(), 1'b0));
               len = $urandom_range(0, 5);
               for (int k = 0; k < len; k++) begin
                  case ($urandom_range(0, 2))
                     0:       c = rand_letter();
                     1:       c = rand_digit();
                     default: c = CH_UNDER;
                  endcase
                  add_text(pr(c, 1'b0));
               end
            end
            3, 4: begin
               add_text(pr(rand_digit(), 1'b0));
               len = $urandom_range(0, 4);
               for (int k = 0; k < len; k++)
                  add_text(pr(($urandom_range(0, 3) == 0) ? CH_DOT : rand_digit(), 1'b0));
            end
            5, 6: begin
               add_text(pr(CH_QUOTE, 1'b0));
               len = $urandom_range(0, 4);
               for (int k = 0; k < len; k++) begin
                  c = 8'($urandom_range(1, 255));
                  add_text(pr((c == CH_QUOTE) ? 8'h73 : c, 1'b0));
               end
               // leave a few strings open
               if ($urandom_range(0, 7) != 0)
                  add_text(pr(CH_QUOTE, 1'b0));
            end
            7: begin
               case ($urandom_range(0, 3))
                  0:       c = CH_EQ;
                  1:       c = CH_BANG;
                  2:       c = CH_LT;
                  default: c = CH_GT;
               endcase
               add_text(pr(c, 1'b0));
               if ($urandom_range(0, 1) == 0)
                  add_text(pr(CH_EQ, 1'b0));
            end
            8: add_text(pr(8'($urandom_range(1, 255)), 1'b0));
            default: begin
               len = $urandom_range(1, 3);
               for (int k = 0; k < len; k++)
                  add_text(pr(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0));
            end
         endcase
         case ($urandom_range(0, 3))
            0, 1: add_text(pr(rand_blank(), 1'b0));
            2:    ;
            default: begin
               add_text(pr(rand_blank(), 1'b0));
               add_text(pr(rand_blank(), 1'b0));
            end
         endcase
      end
      case ($urandom_range(0, 2))
         0:       add_text(pr(CH_NUL, 1'($urandom_range(0, 1))));
         1:       text_q[text_q.size() - 1].fin = 1'b1;
         default: ;
      endcase
   endfunction

   function void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Called and returns at a falling edge; valid stays high after the beat
   task automatic send_byte(input row_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.char_in    <= r.ch;
      req_bus.final_char <= r.fin;
      do @(posedge clock); while (!req_bus.ready);
      scan_text_byte(r.ch, r.fin);
      if (r.typed) begin
         if (r.cnt > 0) add_expected(r.t0);
         if (r.cnt > 1) add_expected(r.t1);
         if (r.cnt > 2) add_expected(r.t2);
      end else begin
         foreach (step_tokens[i])
            add_expected(step_tokens[i]);
      end
      @(negedge clock);
   endtask

   task automatic await_drain();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (expected_tokens.size() != 0);
   endtask

   task automatic run_random(input int items, input int idle, input int stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (items) begin
         if (text_q.size() == 0)
            compose_text();
         send_byte(text_q.pop_front());
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left    = HOLD_OFF_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      tok_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_tokens.size() == 0) begin
            $error("result with nothing expected: kind %0d char %02h",
                   rsp_bus.token_kind, rsp_bus.char_out);
            fail_count++;
         end else begin
            want = expected_tokens.pop_front();
            check_field("token_kind", want.kind, rsp_bus.token_kind);
            check_field("char_out", want.ch, rsp_bus.char_out);
            check_field("has_char", want.has_ch, rsp_bus.has_char);
            check_field("token_first", want.tfirst, rsp_bus.token_first);
            check_field("token_last", want.tlast, rsp_bus.token_last);
            check_field("item_last", want.ilast, rsp_bus.item_last);
         end
      end
   end

   // watchdog: cycles without a beat on either channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.char_in    = '0;
      req_bus.final_char = 1'b0;
      rsp_bus.ready      = 1'b0;
      clear_scan();

      directed_rows = '{
         tr(CH_NUL, 1'b0, 2'd1, tk(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1), NO_TOK, NO_TOK),
         pr("a", 1'b0),
         pr("b", 1'b0),
         pr(CH_UNDER, 1'b0),
         pr("9", 1'b0),
         pr(" ", 1'b0),
         pr("1", 1'b0),
         pr(CH_DOT, 1'b0),
         pr(CH_LT, 1'b0),
         pr(CH_EQ, 1'b0),
         pr(CH_BANG, 1'b0),
         pr("x", 1'b0),
         pr(CH_QUOTE, 1'b0),
         tr(CH_QUOTE, 1'b0, 2'd1, tk(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1),
            NO_TOK, NO_TOK),
         pr(CH_QUOTE, 1'b0),
         pr("q", 1'b0),
         pr(CH_NUL, 1'b0),
         tr(8'hFF, 1'b1, 2'd2, tk(KIND_SYMBOL, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0),
            tk(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1), NO_TOK),
         pr(CH_QUOTE, 1'b0),
         pr(8'h80, 1'b1),
         pr(CH_GT, 1'b0),
         pr(CH_GT, 1'b0),
         pr(8'h09, 1'b1),
         pr("7", 1'b0),
         pr(CH_NUL, 1'b1)
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i]);
      await_drain();

      run_random(100, 0, 0);
      await_drain();
      run_random(100, 63, 0);
      await_drain();
      run_random(100, 0, 63);
      await_drain();

      // stall the output long enough to back up the input
      hold_request = 1;
      run_random(30, 0, 0);
      await_drain();

      run_random(95, 7, 7);
      await_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/qtt_pkg.sv
design/qtt_if.sv
design/qtt_front.sv
design/qtt_fifo.sv
design/qtt_back.sv
design/query_text_tokenizer.sv
sim/tb.sv
